>>> hdl/tqm_pkg.sv
// types and constants shared by the timer queue cells and controller
package tqm_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;
    localparam int RES_IDX_W   = 4;
    localparam int SLOT_IDX_W  = 8;
    localparam logic [9:0] MS_TO_US = 10'd1000;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    typedef enum logic [2:0] {
        STAT_ADDED     = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EXPIRED   = 3'd4,
        STAT_NOTHING   = 3'd5
    } status_code_t;

    typedef enum logic [1:0] {
        SCAN_FREE = 2'd0,
        SCAN_FIND = 2'd1,
        SCAN_DUE  = 2'd2,
        SCAN_MIN  = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RELOAD = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic                  live;
        logic                  found;
        logic [SLOT_IDX_W-1:0] idx;
        logic [48:0]           deadline;
        logic [31:0]           ident;
        logic [31:0]           period;
    } scan_rec_t;

    typedef struct packed {
        cell_op_t              op;
        logic [SLOT_IDX_W-1:0] idx;
        logic [48:0]           deadline;
        logic [31:0]           ident;
        logic [31:0]           period;
    } cell_cmd_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [47:0] now;
        logic [31:0] key;
    } scan_ctl_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] now;
        logic [31:0] delay_ms;
        logic [31:0] interval_ms;
        logic [31:0] timer_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_id;
        logic        reloaded;
        logic        last;
        logic        pending;
        logic [48:0] earliest_deadline;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_id;
        logic        reloaded;
    } res_ent_t;

endpackage

>>> hdl/tqm_cell.sv
// one timer slot of the chain with its stage of the scan pipeline
module tqm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tqm_pkg::cell_cmd_t  cmd,
    input  tqm_pkg::scan_ctl_t  ctl,
    input  tqm_pkg::scan_rec_t  scan_in,
    output tqm_pkg::scan_rec_t  scan_out
);
    import tqm_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

    logic        valid_reg;
    logic [48:0] deadline_reg;
    logic [31:0] ident_reg;
    logic [31:0] period_reg;
    scan_rec_t   scan_reg;
    scan_rec_t   scan_next;
    logic        hit;
    logic        take;
    logic        earlier;

    assign hit     = (cmd.idx == MY_IDX);
    assign earlier = !scan_in.found || (deadline_reg < scan_in.deadline);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit && cmd.op == OP_WRITE)
        begin
            valid_reg <= 1'b1;
        end
        else if (hit && cmd.op == OP_CLEAR)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.op == OP_WRITE)
        begin
            deadline_reg <= cmd.deadline;
            ident_reg    <= cmd.ident;
            period_reg   <= cmd.period;
        end
        else if (hit && cmd.op == OP_RELOAD)
        begin
            deadline_reg <= cmd.deadline;
        end
    end

    always_comb
    begin
        case (ctl.mode)
            SCAN_FREE: take = !scan_in.found && !valid_reg;
            SCAN_FIND: take = !scan_in.found && valid_reg && (ident_reg == ctl.key);
            SCAN_DUE:  take = valid_reg && (deadline_reg <= {1'b0, ctl.now}) && earlier;
            SCAN_MIN:  take = valid_reg && earlier;
            default:   take = 1'b0;
        endcase
        scan_next = scan_in;
        if (take)
        begin
            scan_next.found    = 1'b1;
            scan_next.idx      = MY_IDX;
            scan_next.deadline = deadline_reg;
            scan_next.ident    = ident_reg;
            scan_next.period   = period_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

>>> hdl/timer_queue_manager.sv
// timer queue: controller over a chain of timer slot cells
// add/delete take two scans, free or find then min, with a slot update between if one is made
// tick: a due scan and slot update per expiry, an empty due scan unless 16 expire,
// then the final min scan; one item at a time, results drain one beat per cycle unless stalled
// the scan token walks one cell per cycle, so the chain length sets how long each scan lasts
// reset: all slots empty, id counter zero, no result pending; slot payload is not cleared
module timer_queue_manager #(
    parameter int NUM_TIMERS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tqm_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output tqm_pkg::rsp_t out_data
);
    import tqm_pkg::*;

    // one-hot controller states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_MUL   = 6'b001000,
        S_APPLY = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    scan_mode_t            mode_reg, mode_next;
    logic [31:0]           next_ident_reg, next_ident_next;
    logic [RES_CNT_W-1:0]  nres_reg, nres_next;
    logic [RES_CNT_W-1:0]  rd_reg, rd_next;
    logic [SLOT_IDX_W-1:0] pick_reg, pick_next;
    logic [31:0]           mul_op_reg, mul_op_next;
    logic [41:0]           mul_reg;
    cell_op_t              op_reg, op_next;
    logic                  pending_reg, pending_next;
    logic [48:0]           earliest_reg, earliest_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_data_reg;

    // result buffer: results are held until the final scan gives pending/earliest
    res_ent_t              res_mem [MAX_RESULTS];
    logic                  buf_we;
    res_ent_t              buf_wdata;
    logic                  out_load;
    logic                  out_free;

    scan_rec_t             chain [NUM_TIMERS+1];
    scan_rec_t             tail;
    scan_ctl_t             ctl;
    cell_cmd_t             cmd;
    logic [NUM_TIMERS:0]   live_vec;

    // scan token enters cell 0 for one cycle and leaves the last cell
    always_comb
    begin
        chain[0]      = '0;
        chain[0].live = (state_reg == S_SCAN);
    end

    assign tail     = chain[NUM_TIMERS];
    assign ctl.mode = mode_reg;
    assign ctl.now  = req_reg.now;
    assign ctl.key  = req_reg.timer_id;

    // slot update is broadcast during the apply cycle only
    assign cmd.op       = (state_reg == S_APPLY) ? op_reg : OP_NONE;
    assign cmd.idx      = pick_reg;
    assign cmd.deadline = {1'b0, req_reg.now} + 49'(mul_reg);
    assign cmd.ident    = next_ident_reg;
    assign cmd.period   = req_reg.interval_ms;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            tqm_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .ctl      (ctl),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1])
            );
        end
        for (gi = 0; gi <= NUM_TIMERS; gi++)
        begin : g_live
            assign live_vec[gi] = chain[gi].live;
        end
    endgenerate

    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        mode_next       = mode_reg;
        next_ident_next = next_ident_reg;
        nres_next       = nres_reg;
        rd_next         = rd_reg;
        pick_next       = pick_reg;
        mul_op_next     = mul_op_reg;
        op_next         = op_reg;
        pending_next    = pending_reg;
        earliest_next   = earliest_reg;
        out_valid_next  = out_valid_reg && out_stall;
        buf_we          = 1'b0;
        buf_wdata       = '0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_data;
                    nres_next = '0;
                    case (in_data.req_type)
                        REQ_ADD:
                        begin
                            mode_next  = SCAN_FREE;
                            state_next = S_SCAN;
                        end
                        REQ_DELETE:
                        begin
                            mode_next  = SCAN_FIND;
                            state_next = S_SCAN;
                        end
                        REQ_TICK:
                        begin
                            mode_next  = SCAN_DUE;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (tail.live)
                begin
                    pick_next = tail.idx;
                    case (mode_reg)
                        SCAN_FREE:
                        begin
                            buf_we    = 1'b1;
                            nres_next = nres_reg + 1'b1;
                            if (tail.found)
                            begin
                                next_ident_next     = next_ident_reg + 32'd1;
                                buf_wdata.status    = STAT_ADDED;
                                buf_wdata.result_id = next_ident_reg + 32'd1;
                                mul_op_next         = req_reg.delay_ms;
                                op_next             = OP_WRITE;
                                state_next          = S_MUL;
                            end
                            else
                            begin
                                buf_wdata.status = STAT_FULL;
                                mode_next        = SCAN_MIN;
                                state_next       = S_SCAN;
                            end
                        end
                        SCAN_FIND:
                        begin
                            buf_we              = 1'b1;
                            nres_next           = nres_reg + 1'b1;
                            buf_wdata.result_id = req_reg.timer_id;
                            if (tail.found)
                            begin
                                buf_wdata.status = STAT_DELETED;
                                op_next          = OP_CLEAR;
                                state_next       = S_APPLY;
                            end
                            else
                            begin
                                buf_wdata.status = STAT_NOT_FOUND;
                                mode_next        = SCAN_MIN;
                                state_next       = S_SCAN;
                            end
                        end
                        SCAN_DUE:
                        begin
                            if (tail.found)
                            begin
                                buf_we              = 1'b1;
                                nres_next           = nres_reg + 1'b1;
                                buf_wdata.status    = STAT_EXPIRED;
                                buf_wdata.result_id = tail.ident;
                                buf_wdata.reloaded  = (tail.period != 32'd0);
                                if (tail.period != 32'd0)
                                begin
                                    mul_op_next = tail.period;
                                    op_next     = OP_RELOAD;
                                    state_next  = S_MUL;
                                end
                                else
                                begin
                                    op_next    = OP_CLEAR;
                                    state_next = S_APPLY;
                                end
                            end
                            else
                            begin
                                // a tick with no expiry still gives one beat
                                if (nres_reg == '0)
                                begin
                                    buf_we           = 1'b1;
                                    nres_next        = RES_CNT_W'(1);
                                    buf_wdata.status = STAT_NOTHING;
                                end
                                mode_next  = SCAN_MIN;
                                state_next = S_SCAN;
                            end
                        end
                        SCAN_MIN:
                        begin
                            pending_next  = tail.found;
                            earliest_next = tail.found ? tail.deadline : 49'd0;
                            rd_next       = '0;
                            state_next    = S_DRAIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // more expiries are searched until the beat limit
                if (req_reg.req_type == REQ_TICK && nres_reg < RES_CNT_W'(MAX_RESULTS))
                begin
                    mode_next = SCAN_DUE;
                end
                else
                begin
                    mode_next = SCAN_MIN;
                end
                state_next = S_SCAN;
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    rd_next        = rd_reg + 1'b1;
                    if (rd_reg + 1'b1 == nres_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= SCAN_FREE;
            next_ident_reg <= '0;
            nres_reg       <= '0;
            rd_reg         <= '0;
            op_reg         <= OP_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            next_ident_reg <= next_ident_next;
            nres_reg       <= nres_next;
            rd_reg         <= rd_next;
            op_reg         <= op_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pick_reg     <= pick_next;
        mul_op_reg   <= mul_op_next;
        mul_reg      <= mul_op_reg * MS_TO_US;
        pending_reg  <= pending_next;
        earliest_reg <= earliest_next;
    end

    // result buffer write and registered read into the output beat
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            res_mem[nres_reg[RES_IDX_W-1:0]] <= buf_wdata;
        end
        if (out_load)
        begin
            out_data_reg.status            <= res_mem[rd_reg[RES_IDX_W-1:0]].status;
            out_data_reg.result_id         <= res_mem[rd_reg[RES_IDX_W-1:0]].result_id;
            out_data_reg.reloaded          <= res_mem[rd_reg[RES_IDX_W-1:0]].reloaded;
            out_data_reg.last              <= (rd_reg + 1'b1 == nres_reg);
            out_data_reg.pending           <= pending_reg;
            out_data_reg.earliest_deadline <= earliest_reg;
        end
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_vec))
        else $error("more than one scan token in the chain");

    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> nres_reg != '0)
        else $error("drain with no buffered result");

    a_earliest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.pending |-> out_data_reg.earliest_deadline == 49'd0)
        else $error("earliest deadline set with no timer pending");

    a_apply_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |=> state_reg == S_SCAN)
        else $error("slot update not followed by a scan");

endmodule
